// File: src/wsd_pkg.sv
// wsd_pkg: shared types and constants of the work-stealing job deque
// no dependencies; used by every other file of the block
package wsd_pkg;

    // fixed field widths of the request and response words
    localparam int JOB_W = 32;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;
    localparam int CNT_W = 7;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_STEAL = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // status codes
    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-word result fields other than the handle
    typedef struct packed {
        logic             got_job;
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_meta;

endpackage

// File: src/wsd_req_if.sv
// wsd_req_if: request channel of the deque (valid/ready plus op and handle)
// depends on wsd_pkg
interface wsd_req_if;
    logic                       valid;
    logic                       ready;
    logic [wsd_pkg::OP_W-1:0]   op;
    logic [wsd_pkg::JOB_W-1:0]  job_in;

    modport source (output valid, output op, output job_in, input ready);
    modport sink   (input valid, input op, input job_in, output ready);
endinterface

// File: src/wsd_rsp_if.sv
// wsd_rsp_if: response channel of the deque (valid/ready plus result fields)
// depends on wsd_pkg
interface wsd_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [wsd_pkg::JOB_W-1:0]  job_out;
    logic                       got_job;
    logic [wsd_pkg::ST_W-1:0]   status;
    logic [wsd_pkg::CNT_W-1:0]  count;

    modport source (output valid, output job_out, output got_job, output status,
                    output count, input ready);
    modport sink   (input valid, input job_out, input got_job, input status,
                    input count, output ready);
endinterface

// File: src/wsd_ring.sv
// wsd_ring: ring storage of job handles, one write and one registered read port
// depends on wsd_pkg
module wsd_ring #(
    parameter int DEPTH       = 64,
    parameter int HANDLE_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [wsd_pkg::JOB_W-1:0]  i_wr_job,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [wsd_pkg::JOB_W-1:0]  o_rd_job
);

    logic [HANDLE_BITS-1:0] r_mem [DEPTH];
    logic [HANDLE_BITS-1:0] r_rdata;
    logic [63:0]            w_wr_ext;
    logic [63:0]            w_rd_ext;

    // handle masked to the stored width
    assign w_wr_ext = 64'(i_wr_job);

    // write and registered read; read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= w_wr_ext[HANDLE_BITS-1:0];
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    // stored handle back to the 32-bit field
    assign w_rd_ext = 64'(r_rdata);
    assign o_rd_job = w_rd_ext[wsd_pkg::JOB_W-1:0];

endmodule

// File: src/wsd_ctrl.sv
// wsd_ctrl: top/bottom pointers, operation decode and the read-stage register
// depends on wsd_pkg
module wsd_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [wsd_pkg::OP_W-1:0]   i_op,
    input  logic                       i_take,
    output logic                       o_ready,
    output logic                       o_wr_en,
    output logic [$clog2(DEPTH)-1:0]   o_wr_addr,
    output logic                       o_rd_en,
    output logic [$clog2(DEPTH)-1:0]   o_rd_addr,
    output logic                       o_s1_vld,
    output wsd_pkg::t_meta             o_s1_meta
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int PTR_W = IDX_W + 1;

    logic [PTR_W-1:0] r_bot, n_bot;
    logic [PTR_W-1:0] r_top, n_top;
    logic             r_s1_vld, n_s1_vld;
    wsd_pkg::t_meta   r_s1_meta, n_s1_meta;

    logic             w_accept;
    logic [PTR_W-1:0] w_cnt;
    logic [PTR_W-1:0] w_cnt_after;
    logic [31:0]      w_cnt_ext;
    logic             w_full;
    logic             w_empty;

    // accept when the read stage is empty or moving on
    assign o_ready  = !r_s1_vld || i_take;
    assign w_accept = i_valid && o_ready;

    assign w_cnt   = r_bot - r_top;
    assign w_full  = (w_cnt == PTR_W'(DEPTH));
    assign w_empty = (w_cnt == '0);

    // decode one operation against the current pointers
    always_comb begin
        n_bot     = r_bot;
        n_top     = r_top;
        o_wr_en   = 1'b0;
        o_rd_en   = 1'b0;
        o_wr_addr = r_bot[IDX_W-1:0];
        o_rd_addr = r_top[IDX_W-1:0];
        n_s1_meta = '{got_job: 1'b0, status: wsd_pkg::ST_DONE, count: '0};
        case (wsd_pkg::t_op'(i_op))
            wsd_pkg::OP_PUSH: begin
                if (w_full) begin
                    n_s1_meta.status = wsd_pkg::ST_FULL;
                end else begin
                    o_wr_en = w_accept;
                    n_bot   = r_bot + 1'b1;
                end
            end
            wsd_pkg::OP_POP: begin
                if (w_empty) begin
                    n_s1_meta.status = wsd_pkg::ST_EMPTY;
                end else begin
                    n_bot             = r_bot - 1'b1;
                    o_rd_en           = w_accept;
                    o_rd_addr         = n_bot[IDX_W-1:0];
                    n_s1_meta.got_job = 1'b1;
                end
            end
            wsd_pkg::OP_STEAL: begin
                if (w_empty) begin
                    n_s1_meta.status = wsd_pkg::ST_EMPTY;
                end else begin
                    n_top             = r_top + 1'b1;
                    o_rd_en           = w_accept;
                    n_s1_meta.got_job = 1'b1;
                end
            end
            wsd_pkg::OP_CLEAR: begin
                n_bot = '0;
                n_top = '0;
            end
            default: begin
                n_bot = r_bot;
                n_top = r_top;
            end
        endcase
        w_cnt_after     = n_bot - n_top;
        w_cnt_ext       = 32'(w_cnt_after);
        n_s1_meta.count = w_cnt_ext[wsd_pkg::CNT_W-1:0];
    end

    // read-stage valid
    always_comb begin
        n_s1_vld = r_s1_vld;
        if (w_accept) begin
            n_s1_vld = 1'b1;
        end else if (i_take) begin
            n_s1_vld = 1'b0;
        end
    end

    // pointers and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bot    <= '0;
            r_top    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            if (w_accept) begin
                r_bot <= n_bot;
                r_top <= n_top;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_meta <= n_s1_meta;
        end
    end

    assign o_s1_vld  = r_s1_vld;
    assign o_s1_meta = r_s1_meta;

    // held count never exceeds the ring size
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt <= PTR_W'(DEPTH))
        else $error("deque count beyond depth");

    // pop or steal on an empty queue leaves the pointers alone
    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_empty &&
        (i_op == wsd_pkg::OP_POP || i_op == wsd_pkg::OP_STEAL)
        |=> $stable(r_bot) && $stable(r_top))
        else $error("pointer moved on empty pop or steal");

    // a word held in the read stage is never overwritten
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !i_take |-> !w_accept)
        else $error("read stage overwritten");

endmodule

// File: src/wsd_outreg.sv
// wsd_outreg: result register of the deque, fed from the read stage
// depends on wsd_pkg
module wsd_outreg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s1_vld,
    input  wsd_pkg::t_meta             i_s1_meta,
    input  logic [wsd_pkg::JOB_W-1:0]  i_rd_job,
    input  logic                       i_ready,
    output logic                       o_take,
    output logic                       o_valid,
    output logic [wsd_pkg::JOB_W-1:0]  o_job_out,
    output wsd_pkg::t_meta             o_meta
);

    logic                       r_vld;
    logic [wsd_pkg::JOB_W-1:0]  r_job;
    wsd_pkg::t_meta             r_meta;

    // load when empty or when the current word is taken
    assign o_take = i_s1_vld && (!r_vld || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_take) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    // handle only when a job was taken
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_job  <= i_s1_meta.got_job ? i_rd_job : '0;
            r_meta <= i_s1_meta;
        end
    end

    assign o_valid   = r_vld;
    assign o_job_out = r_job;
    assign o_meta    = r_meta;

    // a returned job always reports done
    a_got_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_meta.got_job |-> r_meta.status == wsd_pkg::ST_DONE)
        else $error("job returned with non-done status");

endmodule

// File: src/work_stealing_deque_top.sv
// work_stealing_deque_top: job deque with owner push/pop and thief steal
// depends on wsd_pkg, wsd_req_if, wsd_rsp_if, wsd_ctrl, wsd_ring, wsd_outreg
//
// Usage: requests come in on i_req (op, job_in); each accepted word gives
// exactly one response word on o_rsp (job_out, got_job, status, count).
// op push stores job_in at the bottom, pop takes the newest job back,
// steal takes the oldest job, clear empties the queue. A push on a full
// ring is refused with status full; pop or steal on an empty ring answers
// status empty with got_job low.
// Path: an accepted word is held in the read stage, then in the result register.
// Throughput: one operation per cycle while o_rsp keeps taking words; a push, pop
// or steal that moves a pointer uses the single ring write port or registered read port once.
// Reset: synchronous, active low; both pointers go to zero (empty queue),
// ring contents are left as they were and are never read before written.
// Stall: a read stage and the result register give two words of slack,
// so i_req.ready stays high for one more word while o_rsp is held off.
module work_stealing_deque_top #(
    parameter int DEPTH       = 64,
    parameter int HANDLE_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wsd_req_if.sink         i_req,
    wsd_rsp_if.source       o_rsp
);

    localparam int IDX_W = $clog2(DEPTH);

    logic                       w_take;
    logic                       w_wr_en;
    logic [IDX_W-1:0]           w_wr_addr;
    logic                       w_rd_en;
    logic [IDX_W-1:0]           w_rd_addr;
    logic                       w_s1_vld;
    wsd_pkg::t_meta             w_s1_meta;
    logic [wsd_pkg::JOB_W-1:0]  w_rd_job;
    wsd_pkg::t_meta             w_out_meta;

    // pointer control and read stage
    wsd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_req.valid),
        .i_op      (i_req.op),
        .i_take    (w_take),
        .o_ready   (i_req.ready),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .o_s1_vld  (w_s1_vld),
        .o_s1_meta (w_s1_meta)
    );

    // handle storage
    wsd_ring #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_job  (i_req.job_in),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_job  (w_rd_job)
    );

    // result register
    wsd_outreg u_outreg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1_vld  (w_s1_vld),
        .i_s1_meta (w_s1_meta),
        .i_rd_job  (w_rd_job),
        .i_ready   (o_rsp.ready),
        .o_take    (w_take),
        .o_valid   (o_rsp.valid),
        .o_job_out (o_rsp.job_out),
        .o_meta    (w_out_meta)
    );

    assign o_rsp.got_job = w_out_meta.got_job;
    assign o_rsp.status  = w_out_meta.status;
    assign o_rsp.count   = w_out_meta.count;

endmodule

// File: sim/wsd_checker.sv
`timescale 1ns / 1ps
// wsd_checker: watches the request and response channels of the job deque,
// predicts every response word and compares it; depends on wsd_pkg, wsd_req_if, wsd_rsp_if
module wsd_checker #(
    parameter int DEPTH       = 64,
    parameter int HANDLE_BITS = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    wsd_req_if     i_req,
    wsd_rsp_if     i_rsp,
    output int     o_errors,
    output int     o_pending
);

    localparam int JOB_W = wsd_pkg::JOB_W;
    localparam int CNT_W = wsd_pkg::CNT_W;
    localparam int PTR_W = $clog2(DEPTH) + 1;
    localparam int IDX_W = PTR_W - 1;
    localparam logic [JOB_W-1:0] HANDLE_MASK = (HANDLE_BITS >= JOB_W) ? {JOB_W{1'b1}} :
        JOB_W'((64'd1 << HANDLE_BITS) - 64'd1);

    typedef struct packed {
        logic [JOB_W-1:0] job;
        wsd_pkg::t_meta   meta;
    } t_answer;

    // predicted deque contents and its two ends
    logic [JOB_W-1:0] jobs_held [DEPTH];
    logic [PTR_W-1:0] owner_end;
    logic [PTR_W-1:0] thief_end;

    t_answer answers_q [$];
    t_answer want;
    int      rsp_words;

    // applies one operation to the predicted deque and returns its answer
    function automatic t_answer predict_deque(wsd_pkg::t_op op, logic [JOB_W-1:0] job);
        t_answer          ans;
        logic [PTR_W-1:0] held;
        ans             = '0;
        ans.meta.status = wsd_pkg::ST_DONE;
        held            = owner_end - thief_end;
        case (op)
            wsd_pkg::OP_PUSH: begin
                if (held >= DEPTH) begin
                    ans.meta.status = wsd_pkg::ST_FULL;
                end else begin
                    jobs_held[owner_end[IDX_W-1:0]] = job & HANDLE_MASK;
                    owner_end = owner_end + 1'b1;
                end
            end
            wsd_pkg::OP_POP: begin
                if (held == 0) begin
                    ans.meta.status = wsd_pkg::ST_EMPTY;
                end else begin
                    owner_end        = owner_end - 1'b1;
                    ans.job          = jobs_held[owner_end[IDX_W-1:0]];
                    ans.meta.got_job = 1'b1;
                end
            end
            wsd_pkg::OP_STEAL: begin
                if (held == 0) begin
                    ans.meta.status = wsd_pkg::ST_EMPTY;
                end else begin
                    ans.job          = jobs_held[thief_end[IDX_W-1:0]];
                    thief_end        = thief_end + 1'b1;
                    ans.meta.got_job = 1'b1;
                end
            end
            default: begin
                owner_end = '0;
                thief_end = '0;
            end
        endcase
        ans.meta.count = CNT_W'(PTR_W'(owner_end - thief_end));
        return ans;
    endfunction

    task automatic report_mismatch(string field, logic [JOB_W-1:0] want_v,
                                   logic [JOB_W-1:0] got_v);
        $display("%0t ns: response word %0d %s: expected %h, got %h",
                 $realtime, rsp_words, field, want_v, got_v);
        o_errors = o_errors + 1;
    endtask

    // responses are checked before the request of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            answers_q.delete();
            owner_end = '0;
            thief_end = '0;
            o_errors  = 0;
            rsp_words = 0;
        end else begin
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (answers_q.size() == 0) begin
                    report_mismatch("unexpected word", '0, i_rsp.job_out);
                end else begin
                    want = answers_q.pop_front();
                    if (i_rsp.job_out !== want.job)
                        report_mismatch("job_out", want.job, i_rsp.job_out);
                    if (i_rsp.got_job !== want.meta.got_job)
                        report_mismatch("got_job", JOB_W'(want.meta.got_job),
                                        JOB_W'(i_rsp.got_job));
                    if (i_rsp.status !== want.meta.status)
                        report_mismatch("status", JOB_W'(want.meta.status),
                                        JOB_W'(i_rsp.status));
                    if (i_rsp.count !== want.meta.count)
                        report_mismatch("count", JOB_W'(want.meta.count),
                                        JOB_W'(i_rsp.count));
                end
                rsp_words = rsp_words + 1;
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                answers_q.push_back(predict_deque(wsd_pkg::t_op'(i_req.op), i_req.job_in));
        end
        o_pending = answers_q.size();
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// tb: drives directed and random deque operations into work_stealing_deque_top
// with random idling and back-pressure; depends on wsd_pkg, the channel interfaces, wsd_checker
module tb;

    localparam int JOB_W       = wsd_pkg::JOB_W;
    localparam int DEPTH       = 64;
    localparam int HANDLE_BITS = 32;
    localparam int TOTAL_WORDS = 1950;
    localparam int QUIET_WORDS = 300;
    localparam int HOLD_CYCLES = 90;
    localparam int TAIL_CYCLES = 20;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN,
        MIX_ROTATE,
        MIX_NOISE
    } t_mix;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;

    // quiet and hold_req are shared between stimulus and receiver
    bit   quiet;
    bit   sender_idles;
    bit   hold_req;
    int   words_sent;

    wsd_req_if req_ch ();
    wsd_rsp_if rsp_ch ();

    work_stealing_deque_top #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    wsd_checker #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_rsp     (rsp_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // offers one word, with an optional gap first, and returns at the accepting edge
    task automatic send_word(wsd_pkg::t_op op, logic [JOB_W-1:0] job);
        if (!quiet && sender_idles && $urandom_range(0, 7) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.op     <= op;
        req_ch.job_in <= job;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        words_sent++;
    endtask

    // sender goes quiet until every response word has come back
    task automatic wait_all_answered();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    // mostly random handles, with zero, all ones and single bits mixed in
    function automatic logic [JOB_W-1:0] random_job();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return JOB_W'(1) << $urandom_range(0, JOB_W - 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic wsd_pkg::t_op pick_op(t_mix mix);
        int unsigned r;
        int unsigned push_lim;
        int unsigned pop_lim;
        r = $urandom_range(0, 99);
        if (mix == MIX_NOISE)
            return wsd_pkg::t_op'($urandom_range(0, 3));
        if (r == 0)
            return wsd_pkg::OP_CLEAR;
        case (mix)
            MIX_FILL:   begin push_lim = 75; pop_lim = 85; end
            MIX_DRAIN:  begin push_lim = 20; pop_lim = 60; end
            MIX_ROTATE: begin push_lim = 50; pop_lim = 50; end
            default:    begin push_lim = 50; pop_lim = 75; end
        endcase
        if (r < push_lim)
            return wsd_pkg::OP_PUSH;
        else if (r < pop_lim)
            return wsd_pkg::OP_POP;
        return wsd_pkg::OP_STEAL;
    endfunction

    // response side: random ready bursts, long holds on request, none when quiet
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            if (hold_req && !quiet) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (quiet || $urandom_range(0, 1) == 0) begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        t_mix mix;
        int   burst_len;
        i_rst_n       = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.op     = wsd_pkg::OP_PUSH;
        req_ch.job_in = '0;
        quiet         = 1'b0;
        sender_idles  = 1'b0;
        hold_req      = 1'b0;
        words_sent    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty ends, zero handle, extremes, LIFO vs FIFO order, clear
        send_word(wsd_pkg::OP_POP,   '0);
        send_word(wsd_pkg::OP_STEAL, '0);
        send_word(wsd_pkg::OP_PUSH,  32'h0000_0000);
        send_word(wsd_pkg::OP_PUSH,  32'hFFFF_FFFF);
        send_word(wsd_pkg::OP_PUSH,  32'hAAAA_AAAA);
        send_word(wsd_pkg::OP_PUSH,  32'h5555_5555);
        send_word(wsd_pkg::OP_POP,   32'hFFFF_FFFF);
        send_word(wsd_pkg::OP_STEAL, '0);
        send_word(wsd_pkg::OP_STEAL, '0);
        send_word(wsd_pkg::OP_POP,   '0);
        send_word(wsd_pkg::OP_POP,   '0);
        send_word(wsd_pkg::OP_STEAL, '1);
        send_word(wsd_pkg::OP_CLEAR, '1);
        send_word(wsd_pkg::OP_PUSH,  32'h1234_5678);
        send_word(wsd_pkg::OP_PUSH,  32'h8765_4321);
        send_word(wsd_pkg::OP_CLEAR, '0);
        send_word(wsd_pkg::OP_STEAL, '0);
        send_word(wsd_pkg::OP_PUSH,  32'h0000_0001);
        send_word(wsd_pkg::OP_POP,   '0);

        // long receiver hold while pushing past full, then let everything drain
        hold_req = 1'b1;
        repeat (DEPTH + 6) send_word(wsd_pkg::OP_PUSH, random_job());
        wait_all_answered();

        // random bursts of one operation mix each
        while (words_sent < TOTAL_WORDS) begin
            mix          = t_mix'($urandom_range(0, 4));
            burst_len    = $urandom_range(8, 80);
            sender_idles = $urandom_range(0, 2) != 0;
            if (!quiet && $urandom_range(0, 9) == 0)
                hold_req = 1'b1;
            for (int i = 0; i < burst_len && words_sent < TOTAL_WORDS; i++) begin
                if (words_sent >= TOTAL_WORDS - QUIET_WORDS)
                    quiet = 1'b1;
                send_word(pick_op(mix), random_job());
            end
            if (!quiet && $urandom_range(0, 5) == 0)
                wait_all_answered();
        end

        wait_all_answered();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("work_stealing_deque_top: match");
        else
            $display("work_stealing_deque_top: mismatch");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #(64'd5_000_000);
        $display("work_stealing_deque_top: mismatch");
        $finish;
    end

endmodule
